>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the allocator files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fba_pkg.sv
package fba_pkg;

	localparam int NumFrames = 4096;
	localparam int WordBits  = 32;
	localparam int BmWords   = NumFrames / WordBits;
	localparam int WordAw    = $clog2(BmWords);
	localparam int BitAw     = $clog2(WordBits);
	localparam int FrameW    = 12;
	localparam int CfgW      = 8;
	localparam int ModeW     = 2;

	typedef logic [WordBits-1:0] word_t;
	typedef logic [WordAw-1:0]   waddr_t;
	typedef logic [BitAw-1:0]    bidx_t;
	typedef logic [FrameW-1:0]   frame_t;
	typedef logic [CfgW-1:0]     cfg_t;
	typedef logic [ModeW-1:0]    mode_t;

	localparam mode_t MODE_ALLOC = 2'd0;
	localparam mode_t MODE_FREE  = 2'd1;
	localparam mode_t MODE_TEST  = 2'd2;
	localparam mode_t MODE_NOP   = 2'd3;

	localparam cfg_t MW_RESET = cfg_t'(BmWords);

	typedef struct packed {
		logic   en;
		waddr_t addr;
		word_t  data;
	} wr_req_t;

endpackage

>>> rtl/core/fba_bitmap_mem.sv
`include "assert_macros.svh"

module fba_bitmap_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  fba_pkg::waddr_t  rd_addr,
	output fba_pkg::word_t   rd_data,
	input  fba_pkg::wr_req_t wr
);
	import fba_pkg::*;

	word_t              mem [BmWords];
	word_t              rdata_q;
	logic               rvalid_q;
	logic [BmWords-1:0] row_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// A row never written reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				row_valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

	`FBA_ASSERT_IMP(a_no_rd_wr_overlap, clk, arst_n, wr.en, !rd_en, "read issued during write-back")

endmodule

>>> rtl/core/fba_first_free.sv
module fba_first_free (
	input  logic [fba_pkg::BmWords-1:0] full_vec,
	input  fba_pkg::cfg_t               limit,
	output logic                        found,
	output fba_pkg::waddr_t             word_idx
);
	import fba_pkg::*;

	logic [BmWords-1:0] avail;
	logic [BmWords-1:0] lowest;

	// Candidate words: not full and inside the managed range.
	always_comb begin
		for (int i = 0; i < BmWords; i++) begin
			avail[i] = !full_vec[i] && (i < int'(limit));
		end
	end

	assign lowest = avail & (~avail + BmWords'(1));
	assign found  = |avail;

	always_comb begin
		word_idx = '0;
		for (int i = 0; i < BmWords; i++) begin
			if (lowest[i]) begin
				word_idx = word_idx | waddr_t'(i);
			end
		end
	end

endmodule

>>> rtl/core/frame_bitmap_allocator.sv
// channel   | direction | signals
// ----------+-----------+----------------------------------------------------
// command   | in        | start/busy, mode, page_frame, kernel_page,
//           |           | writable_request
// result    | out       | done strobe, frame_out, present, writable,
//           |           | user_access, changed, bit_set, full_res
// config    | in        | cfg_valid/cfg_ready, cfg_data (managed_words)
//
// Each item is handled in the accept cycle, which looks up the full-word
// summary and issues the bitmap read, and in the next cycle, which modifies
// and writes the word back. The result strobe follows accept through v_s1 and
// done_q; no new item is taken while busy, so reads never overlap a write-back.
// Reset marks every frame free at once (per-row valid bits), no clearing pass.
// The result receiver cannot stall; results are never held back.
`include "assert_macros.svh"

module frame_bitmap_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fba_pkg::mode_t    mode,
	input  fba_pkg::frame_t   page_frame,
	input  logic              kernel_page,
	input  logic              writable_request,
	output logic              done,
	output fba_pkg::frame_t   frame_out,
	output logic              present,
	output logic              writable,
	output logic              user_access,
	output logic              changed,
	output logic              bit_set,
	output logic              full_res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  fba_pkg::cfg_t     cfg_data
);
	import fba_pkg::*;

	cfg_t               mw_q;
	logic [BmWords-1:0] full_q;

	logic    acc;
	logic    srch_found;
	waddr_t  srch_idx;
	waddr_t  rd_addr;
	word_t   rd_word;
	wr_req_t wr;

	logic    v_s1;
	mode_t   mode_s1;
	frame_t  frame_s1;
	logic    kern_s1;
	logic    wreq_s1;
	waddr_t  addr_s1;
	logic    found_s1;

	word_t   free_bits;
	word_t   pick;
	bidx_t   pick_idx;
	word_t   sel_mask;
	bidx_t   sel_bit;

	frame_t  r_frame;
	logic    r_present, r_writable, r_user, r_changed, r_bit, r_full;
	logic    full_upd, full_val;

	logic    done_q;
	frame_t  frame_out_q;
	logic    present_q, writable_q, user_q, changed_q, bit_set_q, full_res_q;

	assign cfg_ready = 1'b1;
	assign busy      = v_s1;
	assign acc       = start && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q <= MW_RESET;
		end else if (cfg_valid) begin
			mw_q <= cfg_data;
		end
	end

	fba_first_free u_first_free (
		.full_vec (full_q),
		.limit    (mw_q),
		.found    (srch_found),
		.word_idx (srch_idx)
	);

	assign rd_addr = (mode == MODE_ALLOC) ? srch_idx : page_frame[FrameW-1:BitAw];

	fba_bitmap_mem u_bitmap_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (rd_addr),
		.rd_data (rd_word),
		.wr      (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1  <= mode;
			frame_s1 <= page_frame;
			kern_s1  <= kernel_page;
			wreq_s1  <= writable_request;
			addr_s1  <= rd_addr;
			found_s1 <= srch_found;
		end
	end

	// Lowest clear bit of the fetched word.
	assign free_bits = ~rd_word;
	assign pick      = free_bits & (~free_bits + WordBits'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < WordBits; i++) begin
			if (pick[i]) begin
				pick_idx = pick_idx | bidx_t'(i);
			end
		end
	end

	assign sel_bit  = frame_s1[BitAw-1:0];
	assign sel_mask = word_t'(1) << sel_bit;

	always_comb begin
		r_frame    = frame_s1;
		r_present  = 1'b0;
		r_writable = 1'b0;
		r_user     = 1'b0;
		r_changed  = 1'b0;
		r_bit      = 1'b0;
		r_full     = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = addr_s1;
		wr.data    = rd_word;
		full_upd   = 1'b0;
		full_val   = 1'b0;
		unique case (mode_s1)
			MODE_ALLOC: begin
				if (frame_s1 != '0) begin
					r_frame = frame_s1;
				end else if (!found_s1) begin
					r_frame = '0;
					r_full  = 1'b1;
				end else begin
					r_frame    = {addr_s1, pick_idx};
					r_present  = 1'b1;
					r_writable = wreq_s1;
					r_user     = !kern_s1;
					r_changed  = 1'b1;
					wr.en      = v_s1;
					wr.data    = rd_word | pick;
					full_upd   = v_s1;
					full_val   = &(rd_word | pick);
				end
			end
			MODE_FREE: begin
				r_frame = '0;
				if (frame_s1 != '0) begin
					r_changed = 1'b1;
					wr.en     = v_s1;
					wr.data   = rd_word & ~sel_mask;
					full_upd  = v_s1;
					full_val  = 1'b0;
				end
			end
			MODE_TEST: begin
				r_bit = rd_word[sel_bit];
			end
			MODE_NOP: begin
				r_frame = frame_s1;
			end
			default: begin
				r_frame = frame_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (full_upd) begin
				full_q[addr_s1] <= full_val;
			end
			done_q <= v_s1;
		end
	end

	// Hold the result for its single strobe cycle.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			frame_out_q <= r_frame;
			present_q   <= r_present;
			writable_q  <= r_writable;
			user_q      <= r_user;
			changed_q   <= r_changed;
			bit_set_q   <= r_bit;
			full_res_q  <= r_full;
		end
	end

	assign done        = done_q;
	assign frame_out   = frame_out_q;
	assign present     = present_q;
	assign writable    = writable_q;
	assign user_access = user_q;
	assign changed     = changed_q;
	assign bit_set     = bit_set_q;
	assign full_res    = full_res_q;

	`FBA_ASSERT_IMP(a_done_after_accept, clk, arst_n, done, $past(start && !busy, 2), "result without an accepted item")
	`FBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe held two cycles")
	`FBA_ASSERT_IMP(a_full_no_change, clk, arst_n, done && full_res, !changed && !present && (frame_out == '0), "full result changed the bitmap")

endmodule
